[hw/rtl/connector_status_indicator_fsm_defines.svh]
// ----------------------------------------------------------------------------
// Connector status indicator assertion macros
// Clocked concurrent assertion helpers used by connector_status_indicator_fsm.
// ----------------------------------------------------------------------------
`ifndef CONNECTOR_STATUS_INDICATOR_FSM_DEFINES_SVH
`define CONNECTOR_STATUS_INDICATOR_FSM_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every rising clock edge outside reset
`define CSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csi assertion failed");
// expr must never be true outside reset
`define CSI_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("csi forbidden condition seen");
`else
`define CSI_ASSERT(lbl, clk, rst_n, prop)
`define CSI_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/csi_pkg.sv]
// ----------------------------------------------------------------------------
// csi_pkg
// Codes, register defaults and the per-channel update function of the
// connector status indicator.
// ----------------------------------------------------------------------------
package csi_pkg;

  // run phase codes
  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  // channel state codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_FADING = 2'd1;
  localparam logic [1:0] ST_FIXED  = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  // light codes
  localparam logic [2:0] LT_NONE        = 3'd0;
  localparam logic [2:0] LT_FADING      = 3'd1;
  localparam logic [2:0] LT_FIXED       = 3'd2;
  localparam logic [2:0] LT_BLINK_PLUS  = 3'd3;
  localparam logic [2:0] LT_BLINK_MINUS = 3'd4;

  // fading token: 0 free, 1..4 channel a..d
  localparam logic [2:0] OWNER_FREE = 3'd0;

  localparam int unsigned NUM_CHAN = 4;

  // register map
  localparam logic REG_STARTUP_WAIT  = 1'b0;
  localparam logic REG_REPORT_PERIOD = 1'b1;

  localparam logic [15:0] STARTUP_WAIT_RST  = 16'd20000;
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd6000;

  typedef struct packed {
    logic [1:0] st;
    logic [2:0] lt;
    logic [2:0] owner;
  } chan_t;

  // One channel step; owner is the shared fading token seen so far.
  function automatic chan_t chan_step(input logic [1:0] st, input logic [2:0] lt,
                                      input logic [2:0] owner, input logic [2:0] me,
                                      input logic p, input logic m);
    chan_t r;
    r.st    = st;
    r.lt    = lt;
    r.owner = owner;
    case (st)
      ST_NONE: begin
        if (p || m) begin
          if (owner == OWNER_FREE) begin
            r.st    = ST_FADING;
            r.lt    = LT_FADING;
            r.owner = me;
          end else if (p) begin
            r.st = ST_BAD;
            r.lt = LT_BLINK_PLUS;
          end else begin
            r.st = ST_BAD;
            r.lt = LT_BLINK_MINUS;
          end
        end
      end
      ST_FADING: begin
        if (p && m) begin
          r.st    = ST_FIXED;
          r.lt    = LT_FIXED;
          r.owner = OWNER_FREE;
        end else if (!p && !m) begin
          r.st = ST_NONE;
          r.lt = LT_NONE;
          if (owner == me) r.owner = OWNER_FREE;
        end
      end
      ST_FIXED: begin
        if (!p || !m) begin
          if (owner == OWNER_FREE) begin
            r.st    = ST_FADING;
            r.lt    = LT_FADING;
            r.owner = me;
          end else if (p) begin
            r.st = ST_BAD;
            r.lt = LT_BLINK_PLUS;
          end else if (m) begin
            r.st = ST_BAD;
            r.lt = LT_BLINK_MINUS;
          end
          // both pins gone while token is held: stay fixed
        end
      end
      default: begin
        if (!p && !m) begin
          r.st = ST_NONE;
          r.lt = LT_NONE;
        end
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/connector_status_indicator_fsm.sv]
// A result is registered: out_valid_o is set the cycle after its update is accepted.
// One item per cycle unless stalled; the four-channel chain is one registered pass.
// Tick items (action 0) only step the wait counter and give no result.
// in_stall_o is high only while a held result is stalled downstream.
// Reset (rst_ni low, async): phase init, counters, channels, token and latches cleared,
// registers back to startup_wait 20000 and report_period 6000.
// ----------------------------------------------------------------------------
// connector_status_indicator_fsm
// Four two-pin connector state machines with a shared fading token, startup
// wait, periodic status report and IS probe change detection.
// ----------------------------------------------------------------------------
`include "connector_status_indicator_fsm_defines.svh"

module connector_status_indicator_fsm
  import csi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  pins_i,
  input  logic        is_plus_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  phase_o,
  output logic [2:0]  light_a_o,
  output logic [2:0]  light_b_o,
  output logic [2:0]  light_c_o,
  output logic [2:0]  light_d_o,
  output logic        report_send_o,
  output logic [7:0]  report_bits_o,
  output logic        report_is_o,
  output logic        probe_change_o
);

  logic [15:0] startup_wait_q, report_period_q;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [1:0]  chan_st_q [NUM_CHAN];
  logic [1:0]  chan_st_d [NUM_CHAN];
  logic [2:0]  chan_lt_q [NUM_CHAN];
  logic [2:0]  chan_lt_d [NUM_CHAN];
  logic [2:0]  owner_q, owner_d;
  logic [7:0]  last_pins_q, last_pins_d;
  logic        is_latched_q, is_latched_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  res_phase_q, res_phase_d;
  logic [2:0]  res_lt_q [NUM_CHAN];
  logic        res_send_q, res_send_d;
  logic [7:0]  res_bits_q, res_bits_d;
  logic        res_is_q, res_is_d;
  logic        res_probe_q, res_probe_d;

  logic        in_accept;
  logic        upd_accept;
  logic        cfg_write;
  chan_t       step;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_REPORT_PERIOD) ? {16'b0, report_period_q}
                                                     : {16'b0, startup_wait_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_wait_q  <= STARTUP_WAIT_RST;
      report_period_q <= REPORT_PERIOD_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_REPORT_PERIOD) begin
        report_period_q <= pwdata[15:0];
      end else begin
        startup_wait_q <= pwdata[15:0];
      end
    end
  end

  // result register frees when its item is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign upd_accept = in_accept && action_i;

  always_comb begin
    phase_d      = phase_q;
    wait_d       = wait_q;
    owner_d      = owner_q;
    last_pins_d  = last_pins_q;
    is_latched_d = is_latched_q;
    res_phase_d  = phase_q;
    res_send_d   = 1'b0;
    res_bits_d   = 8'd0;
    res_is_d     = 1'b0;
    res_probe_d  = 1'b0;
    step         = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      chan_st_d[ch] = chan_st_q[ch];
      chan_lt_d[ch] = chan_lt_q[ch];
    end

    if (in_accept && !action_i) begin
      if (wait_q != 16'd0) wait_d = wait_q - 16'd1;
    end else if (upd_accept) begin
      case (phase_q)
        PH_WAIT: begin
          if (wait_q == 16'd0) phase_d = PH_RUN;
        end
        PH_RUN: begin
          // channels a..d in order, token passed along the chain
          for (int ch = 0; ch < NUM_CHAN; ch++) begin
            step = chan_step(chan_st_q[ch], chan_lt_q[ch], owner_d, 3'(ch + 1),
                             pins_i[7 - 2*ch] || (ch == 0 && is_plus_i),
                             pins_i[6 - 2*ch]);
            chan_st_d[ch] = step.st;
            chan_lt_d[ch] = step.lt;
            owner_d       = step.owner;
          end
          if (pins_i != last_pins_q) begin
            last_pins_d = pins_i;
            res_send_d  = 1'b1;
          end else if (wait_q == 16'd0) begin
            res_send_d = 1'b1;
          end
          if (res_send_d) begin
            res_bits_d = pins_i;
            res_is_d   = is_plus_i;
            wait_d     = report_period_q;
          end
          if (is_plus_i != is_latched_q) begin
            is_latched_d = is_plus_i;
            res_probe_d  = 1'b1;
          end
        end
        default: begin
          // init, and the unused code treated as init
          res_phase_d = PH_INIT;
          phase_d     = PH_WAIT;
          wait_d      = startup_wait_q;
        end
      endcase
    end

    if (upd_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_INIT;
      wait_q       <= 16'd0;
      owner_q      <= OWNER_FREE;
      last_pins_q  <= 8'd0;
      is_latched_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        chan_st_q[ch] <= ST_NONE;
        chan_lt_q[ch] <= LT_NONE;
      end
    end else begin
      phase_q      <= phase_d;
      wait_q       <= wait_d;
      owner_q      <= owner_d;
      last_pins_q  <= last_pins_d;
      is_latched_q <= is_latched_d;
      out_valid_q  <= out_valid_d;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        chan_st_q[ch] <= chan_st_d[ch];
        chan_lt_q[ch] <= chan_lt_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_accept) begin
      res_phase_q <= res_phase_d;
      res_send_q  <= res_send_d;
      res_bits_q  <= res_bits_d;
      res_is_q    <= res_is_d;
      res_probe_q <= res_probe_d;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        res_lt_q[ch] <= chan_lt_d[ch];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phase_o        = res_phase_q;
  assign light_a_o      = res_lt_q[0];
  assign light_b_o      = res_lt_q[1];
  assign light_c_o      = res_lt_q[2];
  assign light_d_o      = res_lt_q[3];
  assign report_send_o  = res_send_q;
  assign report_bits_o  = res_bits_q;
  assign report_is_o    = res_is_q;
  assign probe_change_o = res_probe_q;

  `CSI_ASSERT(a_owner_range, clk_i, rst_ni, owner_q <= 3'd4)
  `CSI_ASSERT_NEVER(a_phase_unused, clk_i, rst_ni, phase_q == 2'd3)
  `CSI_ASSERT(a_flags_only_running, clk_i, rst_ni,
              (out_valid_o && phase_o != PH_RUN) |-> (!report_send_o && !probe_change_o))
  `CSI_ASSERT(a_report_quiet, clk_i, rst_ni,
              (out_valid_o && !report_send_o) |-> (report_bits_o == 8'd0 && !report_is_o))
  `CSI_ASSERT(a_last_pins_track, clk_i, rst_ni,
              (upd_accept && phase_q == PH_RUN) |=> (last_pins_q == $past(pins_i)))

endmodule

[tb/connector_status_indicator_fsm_tb.sv]
// ----------------------------------------------------------------------------
// connector_status_indicator_fsm_tb
// Drives tick and pin-sample items into the connector status indicator,
// gets each status result from a table or an independent model of the
// four channel machines, the shared fading token and the report timer,
// and compares each result field by field. Register writes happen only
// while the block is idle; both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module connector_status_indicator_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csi_pkg::*;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [2:0] ADDR_STARTUP_WAIT  = {REG_STARTUP_WAIT, 2'b00};
  localparam logic [2:0] ADDR_REPORT_PERIOD = {REG_REPORT_PERIOD, 2'b00};

  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS    = 135;

  typedef struct {
    logic [1:0] phase;
    logic [2:0] light_a;
    logic [2:0] light_b;
    logic [2:0] light_c;
    logic [2:0] light_d;
    logic       send;
    logic [7:0] rep_bits;
    logic       rep_is;
    logic       probe;
  } status_t;

  typedef struct {
    logic        act;
    logic [7:0]  pins;
    logic        isp;
    int unsigned reps;
    bit          typed;
    status_t     want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [7:0]  pins_i = '0;
  logic        is_plus_i = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  phase_o;
  logic [2:0]  light_a_o;
  logic [2:0]  light_b_o;
  logic [2:0]  light_c_o;
  logic [2:0]  light_d_o;
  logic        report_send_o;
  logic [7:0]  report_bits_o;
  logic        report_is_o;
  logic        probe_change_o;

  connector_status_indicator_fsm u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pins_i        (pins_i),
    .is_plus_i     (is_plus_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .phase_o       (phase_o),
    .light_a_o     (light_a_o),
    .light_b_o     (light_b_o),
    .light_c_o     (light_c_o),
    .light_d_o     (light_d_o),
    .report_send_o (report_send_o),
    .report_bits_o (report_bits_o),
    .report_is_o   (report_is_o),
    .probe_change_o(probe_change_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  logic [15:0] cfg_startup;
  logic [15:0] cfg_period;
  logic [1:0]  run_ph;
  logic [15:0] tmr;
  logic [1:0]  con_st [4];
  logic [2:0]  con_lt [4];
  logic [2:0]  fade_tok;
  logic [7:0]  seen_pins;
  logic        is_seen;

  status_t     status_due [$];
  status_t     no_status;
  plan_row_t   plan_q [$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_off_req = 1'b0;

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [2:0] blink_code(logic p);
    return p ? LT_BLINK_PLUS : LT_BLINK_MINUS;
  endfunction

  function automatic void con_step(int unsigned c, logic p, logic m);
    logic [2:0] self;
    self = 3'(c + 1);
    case (con_st[c])
      ST_NONE: begin
        if (p || m) begin
          if (fade_tok == OWNER_FREE) begin
            con_st[c] = ST_FADING;
            con_lt[c] = LT_FADING;
            fade_tok  = self;
          end else begin
            con_st[c] = ST_BAD;
            con_lt[c] = blink_code(p);
          end
        end
      end
      ST_FADING: begin
        if (p && m) begin
          con_st[c] = ST_FIXED;
          con_lt[c] = LT_FIXED;
          fade_tok  = OWNER_FREE;
        end else if (!p && !m) begin
          con_st[c] = ST_NONE;
          con_lt[c] = LT_NONE;
          if (fade_tok == self) fade_tok = OWNER_FREE;
        end
      end
      ST_FIXED: begin
        if (!(p && m)) begin
          if (fade_tok == OWNER_FREE) begin
            con_st[c] = ST_FADING;
            con_lt[c] = LT_FADING;
            fade_tok  = self;
          end else if (p || m) begin
            con_st[c] = ST_BAD;
            con_lt[c] = blink_code(p);
          end
          // token held elsewhere and both pins gone: stays fixed
        end
      end
      default: begin
        if (!p && !m) begin
          con_st[c] = ST_NONE;
          con_lt[c] = LT_NONE;
        end
      end
    endcase
  endfunction

  task automatic indicator_step(input logic act, input logic [7:0] pins, input logic isp,
                                output bit has, output status_t r);
    logic p;
    logic m;
    r   = no_status;
    has = 1'b0;
    if (act == ACT_TICK) begin
      if (tmr != 0) tmr--;
    end else begin
      has     = 1'b1;
      r.phase = run_ph;
      case (run_ph)
        PH_WAIT: begin
          if (tmr == 0) run_ph = PH_RUN;
        end
        PH_RUN: begin
          for (int c = 0; c < 4; c++) begin
            // IS input forces the plus pin of channel a
            p = pins[7 - 2 * c] | ((c == 0) && isp);
            m = pins[6 - 2 * c];
            con_step(c, p, m);
          end
          if (pins != seen_pins) begin
            seen_pins = pins;
            r.send    = 1'b1;
          end else if (tmr == 0) begin
            r.send = 1'b1;
          end
          if (r.send) begin
            r.rep_bits = pins;
            r.rep_is   = isp;
            tmr        = cfg_period;
          end
          if (isp != is_seen) begin
            is_seen = isp;
            r.probe = 1'b1;
          end
        end
        default: begin
          r.phase = PH_INIT;
          run_ph  = PH_WAIT;
          tmr     = cfg_startup;
        end
      endcase
      r.light_a = con_lt[0];
      r.light_b = con_lt[1];
      r.light_c = con_lt[2];
      r.light_d = con_lt[3];
    end
  endtask

  function automatic status_t status_of(logic [1:0] ph, logic [2:0] la, logic [2:0] lb,
                                        logic [2:0] lc, logic [2:0] ld, logic send,
                                        logic [7:0] rbits, logic ris, logic probe);
    status_t s;
    s.phase    = ph;
    s.light_a  = la;
    s.light_b  = lb;
    s.light_c  = lc;
    s.light_d  = ld;
    s.send     = send;
    s.rep_bits = rbits;
    s.rep_is   = ris;
    s.probe    = probe;
    return s;
  endfunction

  function automatic void plan(logic act, logic [7:0] pins, logic isp, int unsigned reps,
                               bit typed, status_t want);
    plan_row_t row;
    row.act   = act;
    row.pins  = pins;
    row.isp   = isp;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    plan_q.push_back(row);
  endfunction

  task automatic offer(input logic act, input logic [7:0] p, input logic s, input bit typed,
                       input status_t want);
    int unsigned gap;
    bit          has;
    status_t     r;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pins_i     <= p;
    is_plus_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    indicator_step(act, p, s, has, r);
    if (has) begin
      if (typed) status_due.push_back(want);
      else status_due.push_back(r);
    end
  endtask

  // stop offering and wait until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [15:0] val,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] addr, input logic [15:0] val);
    logic [31:0] rd;
    csr_access(1'b1, addr, val, rd);
    csr_access(1'b0, addr, 16'h0000, rd);
    cmp_field("prdata", val, rd);
    if (addr == ADDR_STARTUP_WAIT) cfg_startup = val;
    else cfg_period = val;
  endtask

  // mostly single-pin plug/unplug steps so channels walk their states, some noise
  task automatic random_run(input int unsigned n, input bit pause_mid, input bit hold_mid);
    logic [7:0]  p;
    logic        s;
    int unsigned r;
    p = 8'($urandom);
    s = 1'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (pause_mid) drain();
        if (hold_mid) hold_off_req = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 25) begin
        offer(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, no_status);
      end else if (r < 88) begin
        if ($urandom_range(3) != 0) p[$urandom_range(7)] = ~p[$urandom_range(7)];
        if ($urandom_range(9) == 0) s = ~s;
        offer(ACT_UPDATE, p, s, 1'b0, no_status);
      end else begin
        p = 8'($urandom);
        s = 1'($urandom);
        offer(ACT_UPDATE, p, s, 1'b0, no_status);
      end
    end
  endtask

  // receiver: random stall, or a long counted hold-off when requested
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    status_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatches++;
      end else begin
        w = status_due.pop_front();
        cmp_field("phase", w.phase, phase_o);
        cmp_field("light_a", w.light_a, light_a_o);
        cmp_field("light_b", w.light_b, light_b_o);
        cmp_field("light_c", w.light_c, light_c_o);
        cmp_field("light_d", w.light_d, light_d_o);
        cmp_field("report_send", w.send, report_send_o);
        cmp_field("report_bits", w.rep_bits, report_bits_o);
        cmp_field("report_is", w.rep_is, report_is_o);
        cmp_field("probe_change", w.probe, probe_change_o);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    no_status   = status_of(PH_INIT, LT_NONE, LT_NONE, LT_NONE, LT_NONE, 1'b0, 8'h00, 1'b0,
                            1'b0);
    cfg_startup = STARTUP_WAIT_RST;
    cfg_period  = REPORT_PERIOD_RST;
    run_ph      = PH_INIT;
    tmr         = '0;
    fade_tok    = OWNER_FREE;
    seen_pins   = '0;
    is_seen     = 1'b0;
    for (int c = 0; c < 4; c++) begin
      con_st[c] = ST_NONE;
      con_lt[c] = LT_NONE;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    csr_access(1'b0, ADDR_STARTUP_WAIT, 16'h0000, rd);
    cmp_field("startup_wait", STARTUP_WAIT_RST, rd);
    csr_access(1'b0, ADDR_REPORT_PERIOD, 16'h0000, rd);
    cmp_field("report_period", REPORT_PERIOD_RST, rd);
    set_reg(ADDR_STARTUP_WAIT, 16'd6);

    // startup: init, short wait, counter stops at zero, then running
    plan(ACT_UPDATE, 8'hFF, 1'b1, 1, 1'b1, no_status);
    plan(ACT_UPDATE, 8'h00, 1'b0, 1, 1'b1, status_of(PH_WAIT, LT_NONE, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b0, 8'h00, 1'b0, 1'b0));
    plan(ACT_TICK, 8'h00, 1'b0, 5, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h00, 1'b0, 1, 1'b1, status_of(PH_WAIT, LT_NONE, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b0, 8'h00, 1'b0, 1'b0));
    plan(ACT_TICK, 8'hFF, 1'b1, 3, 1'b0, no_status);
    plan(ACT_UPDATE, 8'hAA, 1'b1, 1, 1'b1, status_of(PH_WAIT, LT_NONE, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b0, 8'h00, 1'b0, 1'b0));
    // first running update: pins unchanged, timer expired
    plan(ACT_UPDATE, 8'h00, 1'b0, 1, 1'b1, status_of(PH_RUN, LT_NONE, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b1, 8'h00, 1'b0, 1'b0));
    // IS forces channel a plus pin
    plan(ACT_UPDATE, 8'h00, 1'b1, 1, 1'b1, status_of(PH_RUN, LT_FADING, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b0, 8'h00, 1'b0, 1'b1));
    plan(ACT_UPDATE, 8'h40, 1'b1, 1, 1'b1, status_of(PH_RUN, LT_FIXED, LT_NONE, LT_NONE,
                                                     LT_NONE, 1'b1, 8'h40, 1'b1, 1'b0));
    plan(ACT_UPDATE, 8'hC0, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'hC8, 1'b0, 1, 1'b0, no_status);
    // fixed a loses plus while c fades: blinks minus
    plan(ACT_UPDATE, 8'h48, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h08, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h38, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h3C, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h0C, 1'b0, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h3C, 1'b0, 2, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h3E, 1'b0, 1, 1'b0, no_status);
    // b, then c, lose both pins while d holds the token: they stay fixed
    plan(ACT_UPDATE, 8'h0E, 1'b0, 2, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h03, 1'b0, 2, 1'b0, no_status);
    plan(ACT_TICK, 8'hFF, 1'b1, 1, 1'b0, no_status);
    plan(ACT_UPDATE, 8'hFF, 1'b1, 2, 1'b0, no_status);
    plan(ACT_UPDATE, 8'h00, 1'b0, 1, 1'b0, no_status);

    foreach (plan_q[k]) begin
      repeat (plan_q[k].reps)
        offer(plan_q[k].act, plan_q[k].pins, plan_q[k].isp, plan_q[k].typed, plan_q[k].want);
    end
    drain();

    tx_idle_pct = 25;
    rx_idle_pct = 65;
    set_reg(ADDR_REPORT_PERIOD, 16'h0000);
    set_reg(ADDR_STARTUP_WAIT, 16'h0000);
    random_run(RANDOM_ITEMS, 1'b1, 1'b0);
    drain();

    tx_idle_pct = 65;
    rx_idle_pct = 25;
    set_reg(ADDR_REPORT_PERIOD, 16'hFFFF);
    random_run(RANDOM_ITEMS, 1'b0, 1'b0);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_reg(ADDR_REPORT_PERIOD, 16'($urandom_range(6, 1)));
    set_reg(ADDR_STARTUP_WAIT, 16'($urandom));
    random_run(RANDOM_ITEMS, 1'b0, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("connector_status_indicator_fsm_tb: PASS");
    end else begin
      $display("connector_status_indicator_fsm_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("connector_status_indicator_fsm_tb: FAIL");
    $finish;
  end

endmodule
